FILE: sv/mqttrd_pkg.sv
// Shared types and constants for the MQTT receive deframer.
// Used by the parser, the top level and the port checker; no dependencies.
`default_nettype none

package mqttrd_pkg;

    localparam int CFG_W     = 29;
    localparam int LEN_W     = 28;
    localparam int TOPIC_W   = 16;
    localparam int OFF_W     = 18;
    localparam int TDATA_W   = 96;
    localparam int IN_TDATA_W = 8;

    localparam logic [CFG_W-1:0] MAX_PACKET_RESET = 29'd65536;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    // byte roles
    localparam logic [2:0] ROLE_IGNORED   = 3'd0;
    localparam logic [2:0] ROLE_HEADER    = 3'd1;
    localparam logic [2:0] ROLE_LENGTH    = 3'd2;
    localparam logic [2:0] ROLE_TOPIC_LEN = 3'd3;
    localparam logic [2:0] ROLE_TOPIC     = 3'd4;
    localparam logic [2:0] ROLE_PACKET_ID = 3'd5;
    localparam logic [2:0] ROLE_PAYLOAD   = 3'd6;
    localparam logic [2:0] ROLE_OTHER     = 3'd7;

    // events
    localparam logic [3:0] EV_NONE          = 4'd0;
    localparam logic [3:0] EV_CONNACK_OK    = 4'd1;
    localparam logic [3:0] EV_CONNACK_REF   = 4'd2;
    localparam logic [3:0] EV_SUBACK_OK     = 4'd3;
    localparam logic [3:0] EV_SUBACK_REF    = 4'd4;
    localparam logic [3:0] EV_PUBLISH       = 4'd5;
    localparam logic [3:0] EV_PUBLISH_BAD   = 4'd6;
    localparam logic [3:0] EV_BAD_LENGTH    = 4'd7;
    localparam logic [3:0] EV_OVERSIZE      = 4'd8;
    localparam logic [3:0] EV_PINGRESP      = 4'd9;
    localparam logic [3:0] EV_IGNORED       = 4'd10;

    // packet types (upper nibble of the fixed header)
    localparam logic [3:0] TYPE_CONNACK  = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [3:0] TYPE_SUBACK   = 4'd9;
    localparam logic [3:0] TYPE_PINGRESP = 4'd13;

    localparam logic [7:0] SUBACK_FAILURE = 8'h80;
    localparam logic [7:0] CODE_NONE      = 8'hFF;

    // result fields carried on m_tdata; last member sits in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]   payload_length;
        logic [TOPIC_W-1:0] topic_length;
        logic [LEN_W-1:0]   remaining_length;
        logic [1:0]         qos_level;
        logic [7:0]         return_code;
        logic [3:0]         event_res;
        logic [3:0]         packet_type;
    } res_t;

    typedef struct packed {
        logic [2:0] byte_role;
        logic       packet_end;
        res_t       fields;
    } beat_t;

endpackage

`default_nettype wire

FILE: sv/mqttrd_parser.sv
// Per-byte MQTT parser state and update logic for the receive deframer.
// Depends on mqttrd_pkg; the result for the presented byte is combinational.
`default_nettype none

module mqttrd_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          mode,
    input  logic [7:0]                    rx_byte,
    input  logic [mqttrd_pkg::CFG_W-1:0]  max_bytes,
    output mqttrd_pkg::beat_t             beat_next
);
    import mqttrd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [7:0]         header_reg, header_next;
    logic [LEN_W-1:0]   accum_reg, accum_next;
    logic [2:0]         digits_reg, digits_next;
    logic [LEN_W-1:0]   index_reg, index_next;
    logic [TOPIC_W-1:0] topic_reg, topic_next;
    logic [7:0]         code_reg, code_next;
    logic               subref_reg, subref_next;

    logic [CFG_W-1:0]   count;
    logic               oversize;
    logic [LEN_W-1:0]   digit_term;
    logic [LEN_W-1:0]   accum_len;
    logic [2:0]         digits_inc;
    logic               bad_len;
    logic               len_done;
    logic [3:0]         pkt_type;
    logic [LEN_W-1:0]   index_inc;
    logic               body_done;
    logic [TOPIC_W-1:0] topic_body;
    logic [TOPIC_W-1:0] topic_cur;
    logic [OFF_W-1:0]   topic_end;
    logic [OFF_W-1:0]   pub_off;
    logic [2:0]         body_role;
    logic [7:0]         code_body;
    logic               subref_body;
    logic [LEN_W-1:0]   accum_fin;
    logic [7:0]         code_fin;
    logic               subref_fin;
    logic               pub_ok;
    logic [LEN_W-1:0]   payload;
    logic [3:0]         fin_event;

    // bytes counted so far for this packet, including the one presented
    assign count = (phase_reg == PH_HEADER) ? CFG_W'(1)
                 : CFG_W'(2) + CFG_W'(digits_reg) + CFG_W'(index_reg);
    assign oversize = count > max_bytes;

    always_comb begin
        case (digits_reg[1:0])
            2'd0:    digit_term = LEN_W'(rx_byte[6:0]);
            2'd1:    digit_term = LEN_W'({rx_byte[6:0], 7'd0});
            2'd2:    digit_term = LEN_W'({rx_byte[6:0], 14'd0});
            default: digit_term = {rx_byte[6:0], 21'd0};
        endcase
    end

    assign accum_len  = accum_reg + digit_term;
    assign digits_inc = digits_reg + 3'd1;
    assign bad_len    = rx_byte[7] && (digits_inc >= 3'd4);
    assign len_done   = !rx_byte[7] && (accum_len == '0);

    assign pkt_type  = header_reg[7:4];
    assign index_inc = index_reg + LEN_W'(1);
    assign body_done = index_inc >= accum_reg;

    always_comb begin
        topic_body = topic_reg;
        if (pkt_type == TYPE_PUBLISH) begin
            if (index_reg == '0) begin
                topic_body = {rx_byte, 8'h00};
            end else if (index_reg == LEN_W'(1)) begin
                topic_body = {topic_reg[15:8], rx_byte};
            end
        end
    end

    assign topic_cur = (phase_reg == PH_BODY) ? topic_body : topic_reg;
    assign topic_end = OFF_W'(2) + OFF_W'(topic_cur);
    assign pub_off   = topic_end + ((header_reg[2:1] != 2'd0) ? OFF_W'(2) : OFF_W'(0));

    always_comb begin
        body_role = ROLE_OTHER;
        if (pkt_type == TYPE_PUBLISH) begin
            if (index_reg < LEN_W'(2)) begin
                body_role = ROLE_TOPIC_LEN;
            end else if (index_reg < LEN_W'(topic_end)) begin
                body_role = ROLE_TOPIC;
            end else if (index_reg < LEN_W'(pub_off)) begin
                body_role = ROLE_PACKET_ID;
            end else begin
                body_role = ROLE_PAYLOAD;
            end
        end
    end

    assign code_body   = (pkt_type == TYPE_CONNACK && index_reg == LEN_W'(1)) ? rx_byte
                                                                               : code_reg;
    assign subref_body = subref_reg || (pkt_type == TYPE_SUBACK && index_reg >= LEN_W'(2)
                                        && rx_byte == SUBACK_FAILURE);

    assign accum_fin  = (phase_reg == PH_LENGTH) ? accum_len : accum_reg;
    assign code_fin   = (phase_reg == PH_BODY) ? code_body : code_reg;
    assign subref_fin = (phase_reg == PH_BODY) ? subref_body : subref_reg;
    assign pub_ok     = (accum_fin >= LEN_W'(2)) && (LEN_W'(pub_off) <= accum_fin);
    assign payload    = accum_fin - LEN_W'(pub_off);

    always_comb begin
        case (pkt_type)
            TYPE_CONNACK:  fin_event = (code_fin == 8'h00) ? EV_CONNACK_OK : EV_CONNACK_REF;
            TYPE_SUBACK:   fin_event = subref_fin ? EV_SUBACK_REF : EV_SUBACK_OK;
            TYPE_PUBLISH:  fin_event = pub_ok ? EV_PUBLISH : EV_PUBLISH_BAD;
            TYPE_PINGRESP: fin_event = EV_PINGRESP;
            default:       fin_event = EV_IGNORED;
        endcase
    end

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (mode) begin
            phase_next = PH_HEADER;
        end else begin
            case (phase_reg)
                PH_HEADER: phase_next = oversize ? PH_HALT : PH_LENGTH;
                PH_LENGTH: begin
                    if (oversize || bad_len) begin
                        phase_next = PH_HALT;
                    end else if (len_done) begin
                        phase_next = PH_HEADER;
                    end else if (!rx_byte[7]) begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (oversize) begin
                        phase_next = PH_HALT;
                    end else if (body_done) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: phase_next = PH_HALT;
            endcase
        end
    end

    // packet registers and the result beat
    always_comb begin
        header_next = header_reg;
        accum_next  = accum_reg;
        digits_next = digits_reg;
        index_next  = index_reg;
        topic_next  = topic_reg;
        code_next   = code_reg;
        subref_next = subref_reg;
        beat_next   = '0;

        if (mode) begin
            header_next = '0;
            accum_next  = '0;
            digits_next = '0;
            index_next  = '0;
            topic_next  = '0;
            code_next   = CODE_NONE;
            subref_next = 1'b0;
        end else if (phase_reg == PH_HALT) begin
            beat_next = '0;
        end else if (oversize) begin
            beat_next.fields.event_res = EV_OVERSIZE;
            if (phase_reg != PH_HEADER) begin
                beat_next.fields.packet_type      = header_reg[7:4];
                beat_next.fields.qos_level        = header_reg[2:1];
                beat_next.fields.remaining_length = accum_reg;
                beat_next.fields.topic_length     = topic_reg;
            end
        end else if (phase_reg == PH_HEADER) begin
            header_next = rx_byte;
            accum_next  = '0;
            digits_next = '0;
            index_next  = '0;
            topic_next  = '0;
            code_next   = CODE_NONE;
            subref_next = 1'b0;
            beat_next.byte_role          = ROLE_HEADER;
            beat_next.fields.packet_type = rx_byte[7:4];
            beat_next.fields.qos_level   = rx_byte[2:1];
        end else begin
            beat_next.fields.packet_type      = header_reg[7:4];
            beat_next.fields.qos_level        = header_reg[2:1];
            beat_next.fields.remaining_length = accum_fin;
            beat_next.fields.topic_length     = topic_cur;
            if (phase_reg == PH_LENGTH) begin
                accum_next          = accum_len;
                digits_next         = digits_inc;
                beat_next.byte_role = ROLE_LENGTH;
                if (bad_len) begin
                    beat_next.fields.event_res = EV_BAD_LENGTH;
                end
            end else begin
                topic_next          = topic_body;
                code_next           = code_body;
                subref_next         = subref_body;
                index_next          = index_inc;
                beat_next.byte_role = body_role;
            end
            if ((phase_reg == PH_LENGTH && len_done) || (phase_reg == PH_BODY && body_done))
            begin
                beat_next.packet_end       = 1'b1;
                beat_next.fields.event_res = fin_event;
                if (pkt_type == TYPE_CONNACK) begin
                    beat_next.fields.return_code = code_fin;
                end
                if (pkt_type == TYPE_PUBLISH && pub_ok) begin
                    beat_next.fields.payload_length = payload;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            header_reg <= '0;
            accum_reg  <= '0;
            digits_reg <= '0;
            index_reg  <= '0;
            topic_reg  <= '0;
            code_reg   <= CODE_NONE;
            subref_reg <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            accum_reg  <= accum_next;
            digits_reg <= digits_next;
            index_reg  <= index_next;
            topic_reg  <= topic_next;
            code_reg   <= code_next;
            subref_reg <= subref_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/mqtt_receive_deframer_unit.sv
// Top level of the MQTT receive deframer: input register, parser, result register.
// Depends on mqttrd_pkg and mqttrd_parser.
//
//  channel  | direction | beat payload
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tdata = rx_byte; tuser = mode (1 = parser reset)
//  m_*      | out       | tdata = parsed fields; tuser = byte_role; tlast = end
//  cfg_*    | in        | max_packet_bytes, written when cfg_wr_en is high
//
// One byte per cycle sustained while m_tready is high; m_tvalid rises once an accepted
// byte has passed the input register, then the parser logic into the result register.
// The parser state advances as a byte moves from the input register to the result
// register, so the next byte sees the updated state when it reaches the parser.
// Reset is synchronous on aresetn low; the limit returns to 65536.
// A stall on m_tready holds the result; the input register keeps one more byte.
`default_nettype none

module mqtt_receive_deframer_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mqttrd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] mode
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] packet_type, [7:4] event_res, [15:8] return_code, [17:16] qos_level,
    // [45:18] remaining_length, [61:46] topic_length, [89:62] payload_length
    output logic [mqttrd_pkg::TDATA_W-1:0]      m_tdata,
    output logic [2:0]                          m_tuser,   // [2:0] byte_role
    output logic                                m_tlast,   // packet_end
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [mqttrd_pkg::CFG_W-1:0]        cfg_wr_data // [28:0] max_packet_bytes
);
    import mqttrd_pkg::*;

    logic             in_valid_reg;
    logic             in_mode_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    beat_t            out_beat_reg;
    logic [CFG_W-1:0] max_bytes_reg;
    beat_t            beat_next;
    logic             advance;

    // move a byte into the result register whenever that register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload: hold while the byte waits
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_PACKET_RESET;
        end else if (cfg_wr_en) begin
            max_bytes_reg <= cfg_wr_data;
        end
    end

    mqttrd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .mode      (in_mode_reg),
        .rx_byte   (in_byte_reg),
        .max_bytes (max_bytes_reg),
        .beat_next (beat_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_beat_reg <= beat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_beat_reg.fields);
    assign m_tuser  = out_beat_reg.byte_role;
    assign m_tlast  = out_beat_reg.packet_end;

endmodule

`default_nettype wire

FILE: sv/mqttrd_checker.sv
// Port-level checks for the MQTT receive deframer result channel.
// Depends on mqttrd_pkg; bound to mqtt_receive_deframer_unit at the end of the file.
`default_nettype none

module mqttrd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mqttrd_pkg::TDATA_W-1:0] m_tdata,
    input logic [2:0]                     m_tuser,
    input logic                           m_tlast
);
    import mqttrd_pkg::*;

    res_t r;
    assign r = m_tdata[$bits(res_t)-1:0];

    // hold a stalled beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a packet end always reports a completion event
    a_end_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> r.event_res != EV_NONE && r.event_res != EV_BAD_LENGTH
                                && r.event_res != EV_OVERSIZE)
        else $error("packet end without completion event");

    // a header byte never completes a packet
    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ROLE_HEADER |-> !m_tlast && r.event_res == EV_NONE)
        else $error("header byte carries an event");

    // return code only on CONNACK completion
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.event_res != EV_CONNACK_OK && r.event_res != EV_CONNACK_REF
        |-> r.return_code == 8'h00)
        else $error("return code outside CONNACK");

    // payload length only on a delivered PUBLISH
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.event_res != EV_PUBLISH |-> r.payload_length == '0)
        else $error("payload length outside delivered PUBLISH");

endmodule

bind mqtt_receive_deframer_unit mqttrd_checker u_mqttrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
